// ===== rtl/dcwf_pkg.sv =====
// Shared types, constants and the command length table of the command word framer.
`timescale 1ns / 1ps

package dcwf_pkg;

    localparam int WORD_W    = 64;
    localparam int OPC_W     = 6;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 26;
    localparam int IDX_W     = 3;
    localparam int POS_W     = 10;
    localparam int SCALE_W   = 12;
    localparam int DELAY_W   = 26;
    localparam int WIDTH_W   = 14;
    localparam int HEIGHT_W  = 11;
    localparam int SETTLE_W  = 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 8;

    localparam logic [OPC_W-1:0]    OPC_SYNC_FULL  = 6'h29;
    localparam logic [OPC_W-1:0]    OPC_FIRST_FWD  = 6'd8;
    localparam logic [WIDTH_W-1:0]  DEF_WIDTH      = 14'd320;
    localparam logic [HEIGHT_W-1:0] DEF_HEIGHT     = 11'd240;
    localparam logic [SCALE_W-1:0]  LINE_WIDTH_RST = 12'd320;
    localparam logic [DELAY_W-1:0]  DELAY_MAX      = 26'h3FF_FFFF;
    // delay pipeline depth: span stage, scale stage, area stage
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES  = 2'd3;

    typedef enum logic [IDX_W-1:0] {
        REG_H_START    = 3'd0,
        REG_X_SCALE    = 3'd1,
        REG_LINE_WIDTH = 3'd2,
        REG_V_START    = 3'd3,
        REG_Y_SCALE    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ST_SETTLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic ready;
        logic take;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic cfg_write;
    } ctrl_status_t;

    // words per command, by opcode
    function automatic logic [CNT_W-1:0] opc_word_count(input logic [OPC_W-1:0] opc);
        logic [CNT_W-1:0] len;
        case (opc)
            6'd8:    len = 5'd4;
            6'd9:    len = 5'd6;
            6'd10:   len = 5'd12;
            6'd11:   len = 5'd14;
            6'd12:   len = 5'd12;
            6'd13:   len = 5'd14;
            6'd14:   len = 5'd20;
            6'd15:   len = 5'd22;
            6'd36:   len = 5'd2;
            6'd37:   len = 5'd2;
            default: len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/dcwf_ctrl.sv =====
// Controller: settle sequencing after reset or register writes, and input acceptance.
`timescale 1ns / 1ps

module dcwf_ctrl
    import dcwf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t              state_reg, state_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SETTLE;
            settle_reg <= SETTLE_CYCLES;
        end else begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        settle_next = settle_reg;
        cmd.ready   = 1'b0;
        cmd.take    = 1'b0;
        case (state_reg)
            ST_SETTLE: begin
                if (settle_reg == SETTLE_W'(1)) begin
                    state_next = ST_RUN;
                end else begin
                    settle_next = settle_reg - SETTLE_W'(1);
                end
            end
            ST_RUN: begin
                cmd.ready = status.out_free;
                cmd.take  = status.out_free && status.in_valid;
            end
            default: begin
                state_next = ST_SETTLE;
            end
        endcase
        // any register write restarts the delay pipeline
        if (status.cfg_write) begin
            state_next  = ST_SETTLE;
            settle_next = SETTLE_CYCLES;
        end
    end

endmodule

// ===== rtl/dcwf_datapath.sv =====
// Datapath: video registers, interrupt delay pipeline, word counter and output register.
`timescale 1ns / 1ps

module dcwf_datapath
    import dcwf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  ctrl_cmd_t            cmd,
    input  logic [WORD_W-1:0]    cmd_word,
    input  logic                 out_ready,
    output logic                 out_free,
    output logic                 out_valid,
    output logic [WORD_W-1:0]    out_word,
    output logic [OPC_W-1:0]     out_opcode,
    output logic                 first_word,
    output logic                 last_word,
    output logic                 sync_full,
    output logic [DELAY_W-1:0]   irq_delay
);

    // configuration
    logic [CFG_W-1:0]   h_start_reg, v_start_reg;
    logic [SCALE_W-1:0] x_scale_reg, y_scale_reg, line_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_start_reg    <= '0;
            x_scale_reg    <= '0;
            line_width_reg <= LINE_WIDTH_RST;
            v_start_reg    <= '0;
            y_scale_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_H_START:    h_start_reg    <= cfg_wdata;
                REG_X_SCALE:    x_scale_reg    <= cfg_wdata[SCALE_W-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg_wdata[SCALE_W-1:0];
                REG_V_START:    v_start_reg    <= cfg_wdata;
                REG_Y_SCALE:    y_scale_reg    <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // delay pipeline, stage 1: spans
    logic [POS_W-1:0]   h_a, h_b, v_a, v_b, h_span, v_span;
    logic [SCALE_W-1:0] hdelta_reg, hdelta_next;
    logic [POS_W-1:0]   vspan_reg;

    always_comb begin
        h_a    = h_start_reg[16 +: POS_W];
        h_b    = h_start_reg[POS_W-1:0];
        v_a    = v_start_reg[16 +: POS_W];
        v_b    = v_start_reg[POS_W-1:0];
        h_span = (h_a > h_b) ? (h_a - h_b) : (h_b - h_a);
        v_span = (v_a > v_b) ? (v_a - v_b) : (v_b - v_a);
        hdelta_next = (h_span == '0) ? line_width_reg : SCALE_W'(h_span);
    end

    // stage 2: scaled width and height
    logic [2*SCALE_W-1:0]       x_prod;
    logic [POS_W+SCALE_W-1:0]   y_prod;
    logic [WIDTH_W-1:0]         w_calc, width_reg, width_next;
    logic [HEIGHT_W-1:0]        h_calc, height_reg, height_next;

    always_comb begin
        x_prod = hdelta_reg * x_scale_reg;
        y_prod = vspan_reg * y_scale_reg;
        w_calc = x_prod[2*SCALE_W-1:10];
        h_calc = y_prod[POS_W+SCALE_W-1:11];
        width_next  = (x_scale_reg == '0 || w_calc == '0) ? DEF_WIDTH : w_calc;
        height_next = (y_scale_reg == '0 || h_calc == '0) ? DEF_HEIGHT : h_calc;
    end

    // stage 3: area times four, saturated
    logic [WIDTH_W+HEIGHT_W-1:0] area;
    logic [DELAY_W-1:0]          delay_reg, delay_next;

    always_comb begin
        area = width_reg * height_reg;
        delay_next = area[WIDTH_W+HEIGHT_W-1] ? DELAY_MAX
                   : {area[WIDTH_W+HEIGHT_W-2:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        hdelta_reg <= hdelta_next;
        vspan_reg  <= v_span;
        width_reg  <= width_next;
        height_reg <= height_next;
        delay_reg  <= delay_next;
    end

    // command framing
    logic [CNT_W-1:0] words_left_reg, words_left_next;
    logic [OPC_W-1:0] cur_opc_reg, cur_opc_next;
    logic             is_first, is_last, is_sync, fwd;
    logic [CNT_W-1:0] len;

    always_comb begin
        is_first        = (words_left_reg == '0);
        cur_opc_next    = is_first ? cmd_word[61:56] : cur_opc_reg;
        len             = opc_word_count(cur_opc_next);
        words_left_next = is_first ? (len - CNT_W'(1)) : (words_left_reg - CNT_W'(1));
        is_last         = (words_left_next == '0);
        is_sync         = is_last && (cur_opc_next == OPC_SYNC_FULL);
        fwd             = (cur_opc_next >= OPC_FIRST_FWD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_left_reg <= '0;
            cur_opc_reg    <= '0;
        end else if (cmd.take) begin
            words_left_reg <= words_left_next;
            cur_opc_reg    <= cur_opc_next;
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.take && fwd) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && fwd) begin
            out_word   <= cmd_word;
            out_opcode <= cur_opc_next;
            first_word <= is_first;
            last_word  <= is_last;
            sync_full  <= is_sync;
            irq_delay  <= is_sync ? delay_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

endmodule

// ===== rtl/display_command_word_framer.sv =====
// Top level of the display command word framer.
`timescale 1ns / 1ps

// Display command word framer. Takes one 64-bit command list word per
// accepted input word and splits the list into commands: the opcode sits
// in bits 61..56 of a command's first word and a fixed table gives the
// command length (1 to 22 words). Words of opcodes 8 and above go out
// unchanged with opcode, first/last marks and, on the last word of a
// full-sync command (opcode 0x29), the sync flag and an interrupt delay of
// width*height*4 built from the video registers (saturated to 26 bits,
// zero on every other word). Words of opcodes 0..7 are consumed without
// output. A command may span any number of idle cycles.
// Rate: one word per cycle in steady state; the output register frees in
// the same cycle it is taken, so s_tready stays high under continuous
// m_tready. After reset and after every register write, s_tready is held
// low while the three-stage delay pipeline (spans, scale multiplies, area
// multiply) settles.
// Registers (cfg_index): 0 h_start_word, 1 x_scale, 2 line_width,
// 3 v_start_word, 4 y_scale; other indices are ignored. Write only while idle.

module display_command_word_framer
    import dcwf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [63:0] cmd_word

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [63:0] out_word, [89:64] irq_delay, rest 0
    output logic [M_TUSER_W-1:0] m_tuser,   // [5:0] out_opcode, [6] first_word, [7] sync_full
    output logic                 m_tlast    // last_word
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         out_free;

    logic [WORD_W-1:0]  out_word;
    logic [OPC_W-1:0]   out_opcode;
    logic               first_word, sync_full;
    logic [DELAY_W-1:0] irq_delay;

    assign status.in_valid  = s_tvalid;
    assign status.out_free  = out_free;
    assign status.cfg_write = cfg_wr_en;

    dcwf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    dcwf_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .cmd_word   (s_tdata),
        .out_ready  (m_tready),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_word   (out_word),
        .out_opcode (out_opcode),
        .first_word (first_word),
        .last_word  (m_tlast),
        .sync_full  (sync_full),
        .irq_delay  (irq_delay)
    );

    assign s_tready = cmd.ready;
    assign m_tdata  = {(M_TDATA_W-WORD_W-DELAY_W)'(0), irq_delay, out_word};
    assign m_tuser  = {sync_full, first_word, out_opcode};

endmodule

// ===== rtl/dcwf_checker.sv =====
// Port-level checker for the command word framer, bound to the top level.
`timescale 1ns / 1ps

module dcwf_checker
    import dcwf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_wr_en,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // a stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // sync only on the last word of a command
    a_sync_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[7] |-> m_tlast)
        else $error("sync flag without last word");

    // delay is zero unless sync
    a_delay_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[7] |-> m_tdata[89:64] == '0)
        else $error("irq delay on non-sync word");

    // a register write stalls input while the delay settles
    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted right after register write");

    // only opcodes 8 and above are forwarded
    a_fwd_opc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[5:3] != 3'b000)
        else $error("dropped opcode forwarded");

endmodule

bind display_command_word_framer dcwf_checker u_dcwf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

// ===== sim/tb_display_command_word_framer.sv =====
// Self-checking testbench for the display command word framer: command streams in, framed words out.
`timescale 1ns / 1ps

module tb_display_command_word_framer;
    import dcwf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 2000;
    localparam int NUM_PHASES   = 10;
    localparam int DRAIN_CYCLES = 8;     // settle pipeline plus output register, with margin
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 4000;  // watchdog: cycles with no word moving
    localparam int MAX_REPORTS  = 10;

    // opcodes used by name in the stimulus
    localparam logic [OPC_W-1:0] OPC_NOP        = 6'd0;
    localparam logic [OPC_W-1:0] OPC_LONGEST    = 6'd15;
    localparam logic [OPC_W-1:0] OPC_SIX_WORD   = 6'd9;
    localparam logic [OPC_W-1:0] OPC_PLAIN      = 6'd16;
    localparam logic [OPC_W-1:0] OPC_TWO_WORD_A = 6'd36;
    localparam logic [OPC_W-1:0] OPC_TWO_WORD_B = 6'd37;
    localparam logic [OPC_W-1:0] OPC_TOP        = 6'd63;
    localparam logic [OPC_W-1:0] OPC_DROP_TOP   = OPC_FIRST_FWD - 6'd1;

    // first register index past the implemented ones; writes there are ignored
    localparam logic [IDX_W-1:0] IDX_SPARE = IDX_W'(REG_Y_SCALE) + 3'd1;

    localparam int unsigned FALLBACK_W = 320;
    localparam int unsigned FALLBACK_H = 240;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // one framed word as it should leave the block
    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [OPC_W-1:0]   opcode;
        logic               first;
        logic               last;
        logic               sync;
        logic [DELAY_W-1:0] delay;
    } fwd_word_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks command framing on accepted input words, queues
    // the framed words that must come out, and checks them in order.
    // ------------------------------------------------------------------
    class command_frame_tracker;
        logic [CFG_W-1:0]   h_start_word;
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] line_width;
        logic [CFG_W-1:0]   v_start_word;
        logic [SCALE_W-1:0] y_scale;
        logic [CNT_W-1:0]   words_left;
        logic [OPC_W-1:0]   cur_opc;
        fwd_word_t          expected_q[$];
        int                 fails;
        int                 checked;
        int                 syncs;
        int                 saturated;

        function new();
            h_start_word = '0;
            x_scale      = '0;
            line_width   = 12'd320;
            v_start_word = '0;
            y_scale      = '0;
            words_left   = '0;
            cur_opc      = '0;
            fails        = 0;
            checked      = 0;
            syncs        = 0;
            saturated    = 0;
        endfunction

        static function int unsigned cmd_words(logic [OPC_W-1:0] opc);
            if (opc >= OPC_FIRST_FWD && opc <= OPC_LONGEST) begin
                case (opc[2:0])
                    3'd0:    return 4;
                    3'd1:    return 6;
                    3'd2:    return 12;
                    3'd3:    return 14;
                    3'd4:    return 12;
                    3'd5:    return 14;
                    3'd6:    return 20;
                    default: return 22;
                endcase
            end
            if (opc == OPC_TWO_WORD_A || opc == OPC_TWO_WORD_B)
                return 2;
            return 1;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_H_START:    h_start_word = val;
                REG_X_SCALE:    x_scale      = val[SCALE_W-1:0];
                REG_LINE_WIDTH: line_width   = val[SCALE_W-1:0];
                REG_V_START:    v_start_word = val;
                REG_Y_SCALE:    y_scale      = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // distance between the start (25..16) and end (9..0) positions
        function int unsigned span(logic [CFG_W-1:0] w);
            int unsigned a;
            int unsigned b;
            a = w[25:16];
            b = w[POS_W-1:0];
            return (a > b) ? a - b : b - a;
        endfunction

        function int unsigned frame_w();
            int unsigned delta;
            int unsigned w;
            if (x_scale == 0)
                return FALLBACK_W;
            delta = span(h_start_word);
            if (delta == 0)
                delta = line_width;
            w = (delta * x_scale) / 1024;
            return (w == 0) ? FALLBACK_W : w;
        endfunction

        function int unsigned frame_h();
            int unsigned h;
            if (y_scale == 0)
                return FALLBACK_H;
            h = (span(v_start_word) * y_scale) / 2048;
            return (h == 0) ? FALLBACK_H : h;
        endfunction

        function logic [DELAY_W-1:0] irq_delay();
            longint unsigned d;
            d = longint'(frame_w()) * longint'(frame_h()) * 4;
            return (d > DELAY_MAX) ? DELAY_MAX : d[DELAY_W-1:0];
        endfunction

        // called for every word the block accepts
        function void note_word(logic [WORD_W-1:0] w);
            fwd_word_t   e;
            logic        first;
            int unsigned remaining;
            first = (words_left == 0);
            if (first) begin
                cur_opc   = w[61:56];
                remaining = cmd_words(cur_opc) - 1;
            end else begin
                remaining = words_left - 1;
            end
            words_left = remaining[CNT_W-1:0];
            if (cur_opc < OPC_FIRST_FWD)
                return;     // low opcodes are swallowed
            e.word   = w;
            e.opcode = cur_opc;
            e.first  = first;
            e.last   = (remaining == 0);
            e.sync   = e.last && (cur_opc == OPC_SYNC_FULL);
            e.delay  = e.sync ? irq_delay() : '0;
            expected_q.push_back(e);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
                                 logic tlast);
            fwd_word_t e;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected output word %h tuser %h tlast %b",
                             tdata[WORD_W-1:0], tuser, tlast);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.sync) begin
                syncs++;
                if (e.delay == DELAY_MAX)
                    saturated++;
            end
            if (tdata[WORD_W-1:0] !== e.word || tdata[WORD_W +: DELAY_W] !== e.delay ||
                tdata[M_TDATA_W-1:WORD_W+DELAY_W] !== '0 || tuser[OPC_W-1:0] !== e.opcode ||
                tuser[6] !== e.first || tuser[7] !== e.sync || tlast !== e.last) begin
                fails++;
                if (fails <= MAX_REPORTS) begin
                    $display("mismatch %0d exp: word %h opc %h first %b last %b sync %b delay %0d",
                             fails, e.word, e.opcode, e.first, e.last, e.sync, e.delay);
                    $display("mismatch %0d got: word %h opc %h first %b last %b sync %b delay %0d pad %h",
                             fails, tdata[WORD_W-1:0], tuser[OPC_W-1:0], tuser[6], tlast, tuser[7],
                             tdata[WORD_W +: DELAY_W], tdata[M_TDATA_W-1:WORD_W+DELAY_W]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // [63:0] cmd_word
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [63:0] out_word, [89:64] irq_delay, rest 0
    logic [M_TUSER_W-1:0] m_tuser;    // [5:0] out_opcode, [6] first_word, [7] sync_full
    logic                 m_tlast;    // last_word

    display_command_word_framer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    command_frame_tracker tracker;

    // knobs shared by the sender, the receiver and the phase sequencer
    bit sender_gaps_on;
    bit receiver_stalls_on;
    bit hold_req;
    int words_sent;
    int holds_done;
    int idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request so
    // the output register and then s_tready back up.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (receiver_stalls_on && $urandom_range(99) < 25) begin
                stall_left = pick_gap(1'b1);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // output words are checked at the edge they are taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tdata, m_tuser, m_tlast);
    end

    // watchdog: any word moving on either side restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no word moved for %0d cycles, %0d results still due",
                 IDLE_LIMIT, tracker.expected_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving tasks. Each starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken. On return s_tvalid is either
    // already low (a gap was inserted) or still high for the next word.
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(w);
        words_sent++;
        gap = pick_gap(sender_gaps_on);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // n words of one command; the opcode goes into bits 61..56 of the first
    task automatic send_command(input logic [OPC_W-1:0] opc, input int n, input fill_t fill);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO: w = '0;
                FILL_ONES: w = '1;
                default:   w = {$urandom, $urandom};
            endcase
            if (i == 0)
                w[61:56] = opc;
            send_word(w);
        end
    endtask

    // wait out every due result, then the pipeline tail of dropped words
    task automatic drain();
        while (tracker.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] h, input logic [SCALE_W-1:0] xs,
                                input logic [SCALE_W-1:0] lw, input logic [CFG_W-1:0] v,
                                input logic [SCALE_W-1:0] ys);
        write_reg(REG_H_START, h);
        write_reg(REG_X_SCALE, CFG_W'(xs));
        write_reg(REG_LINE_WIDTH, CFG_W'(lw));
        write_reg(REG_V_START, v);
        write_reg(REG_Y_SCALE, CFG_W'(ys));
        // a write past the last register must change nothing
        write_reg(IDX_SPARE + IDX_W'($urandom_range(2)), CFG_W'($urandom));
    endtask

    function automatic logic [SCALE_W-1:0] rand_scale();
        int r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 40) return SCALE_W'($urandom_range(15, 1));
        return SCALE_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] rand_pos_word();
        logic [CFG_W-1:0] w;
        w = CFG_W'($urandom);
        if ($urandom_range(3) == 0)
            w[25:16] = w[POS_W-1:0];    // start equals end
        return w;
    endfunction

    // Mix weighted toward forwarded commands and full syncs.
    function automatic logic [OPC_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 45) return OPC_FIRST_FWD + OPC_W'($urandom_range(7));
        if (r < 60) return OPC_SYNC_FULL;
        if (r < 68) return $urandom_range(1) ? OPC_TWO_WORD_A : OPC_TWO_WORD_B;
        if (r < 80) return OPC_W'($urandom_range(OPC_DROP_TOP));
        return OPC_W'($urandom_range(OPC_TOP));
    endfunction

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        int per_phase;
        int fwd_words;
        int r;
        int n;
        logic [OPC_W-1:0] opc;

        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_H_START;
        cfg_wdata          = '0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_req           = 1'b0;
        words_sent         = 0;
        holds_done         = 0;
        tracker            = new();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at reset register values (320 x 240 frame).
        send_command(OPC_NOP, 1, FILL_ZERO);       // all-zero word, dropped
        send_command(OPC_DROP_TOP, 1, FILL_ONES);  // top dropped opcode
        send_command(OPC_FIRST_FWD, 4, FILL_ZERO); // lowest forwarded opcode
        send_command(OPC_TOP, 1, FILL_ONES);       // all-ones word
        send_command(OPC_SYNC_FULL, 1, FILL_RANDOM);
        send_command(OPC_TWO_WORD_A, 2, FILL_RANDOM);
        send_command(OPC_TWO_WORD_B, 2, FILL_ONES);
        send_command(OPC_PLAIN, 1, FILL_ZERO);
        send_command(OPC_SYNC_FULL, 1, FILL_ONES);
        // leave a six-word command half done; it must resume after the writes
        send_command(OPC_SIX_WORD, 3, FILL_RANDOM);
        stop_sending();
        drain();

        per_phase = RANDOM_WORDS / NUM_PHASES;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            sender_gaps_on     = ($urandom_range(3) != 0);
            receiver_stalls_on = ($urandom_range(3) != 0);
            case (phase)
                0: // everything at its top: width and height large, delay saturates
                    program_regs(26'h3FF_FFFF, 12'hFFF, 12'hFFF, 26'h3FF_0000, 12'hFFF);
                1: // everything zero: both fallbacks
                    program_regs('0, '0, '0, '0, '0);
                2: begin
                    // scales too small: width and height truncate to zero
                    program_regs(26'h005_0004, 12'd1, SCALE_W'($urandom), 26'h000_0001, 12'd1);
                    hold_req       = 1'b1;
                    sender_gaps_on = 1'b0;
                end
                3: // start equals end: width comes from line_width
                    program_regs(26'h123_0123, 12'h400, SCALE_W'($urandom), 26'h000_03FF,
                                 12'h800);
                default: begin
                    program_regs(rand_pos_word(), rand_scale(), SCALE_W'($urandom),
                                 rand_pos_word(), rand_scale());
                    if (phase == NUM_PHASES / 2 + 1) begin
                        hold_req       = 1'b1;
                        sender_gaps_on = 1'b0;
                    end
                end
            endcase

            fwd_words = 0;
            while (fwd_words < per_phase) begin
                r   = $urandom_range(99);
                opc = pick_opcode();
                n   = command_frame_tracker::cmd_words(opc);
                if (r < 4) begin
                    // raw word: whatever it lands on in the framing
                    send_word({$urandom, $urandom});
                end else begin
                    if (r < 8 && n > 1)
                        n = $urandom_range(n - 1, 1);   // cut short, next command misframes
                    send_command(opc, n, FILL_RANDOM);
                    if (opc >= OPC_FIRST_FWD)
                        fwd_words += n;
                end
            end
            stop_sending();
            drain();
        end

        $display("framer run: %0d words in, %0d framed words checked, %0d register settings",
                 words_sent, tracker.checked, NUM_PHASES + 1);
        $display("framer run: %0d full syncs (%0d saturated delays), %0d long output hold-offs",
                 tracker.syncs, tracker.saturated, holds_done);
        if (tracker.expected_q.size() != 0)
            $display("%0d expected words never came out", tracker.expected_q.size());
        if (tracker.fails == 0 && tracker.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", tracker.fails);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dcwf_pkg.sv
rtl/dcwf_ctrl.sv
rtl/dcwf_datapath.sv
rtl/display_command_word_framer.sv
rtl/dcwf_checker.sv
sim/tb_display_command_word_framer.sv
